@@ rtl/ng_pkg.sv @@
// Shared constants, config types and codes for the noise gate with input trim.
`default_nettype none
package ng_pkg;

  // gains, coefficients and thresholds are all 24-bit words
  localparam int unsigned GAIN_W     = 24;
  // multiplier digit size and the number of digits in a 24-bit operand
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned NUM_DIGITS = GAIN_W / DIGIT_W;
  localparam int unsigned DCNT_W     = $clog2(NUM_DIGITS + 1);

  localparam logic [GAIN_W-1:0] ONE_Q23 = 24'd8388608;
  localparam logic [GAIN_W-1:0] ONE_Q20 = 24'd1048576;
  localparam logic [GAIN_W-1:0] EPS_Q20 = 24'd105;
  // 0.01 in Q0.24; the 0.99 weight is one minus this
  localparam logic [GAIN_W-1:0] MOVE_W  = 24'd167772;

  localparam logic [GAIN_W-1:0] THRESHOLD_RST = 24'd838;
  localparam logic [GAIN_W-1:0] RELEASE_RST   = 24'd5800;
  localparam logic [GAIN_W-1:0] TARGET_RST    = ONE_Q20;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GATE_ENABLE    = 2'd0,
    CFG_GATE_THRESHOLD = 2'd1,
    CFG_RELEASE_COEFF  = 2'd2,
    CFG_TARGET_GAIN    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic              gate_enable;
    logic [GAIN_W-1:0] gate_threshold_level;
    logic [GAIN_W-1:0] release_coeff;
    logic [GAIN_W-1:0] target_gain;
  } cfg_t;

endpackage
`default_nettype wire

@@ rtl/ng_intf.sv @@
// Handshake interfaces: sample input, sample output and config write channel.
`default_nettype none
interface ng_in_if #(parameter int unsigned SAMPLE_WIDTH = 24) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface ng_out_if #(parameter int unsigned SAMPLE_WIDTH = 24) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface ng_cfg_if ();
  import ng_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] addr;
  logic [GAIN_W-1:0]    data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/ng_cfg_regs.sv @@
// Configuration register file written through the config channel.
`default_nettype none
module ng_cfg_regs (
  input  logic         clk_i,
  input  logic         rst_ni,
  ng_cfg_if.sink       cfg_i,
  output ng_pkg::cfg_t cfg_o
);
  import ng_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gate_enable          <= 1'b0;
      cfg_q.gate_threshold_level <= THRESHOLD_RST;
      cfg_q.release_coeff        <= RELEASE_RST;
      cfg_q.target_gain          <= TARGET_RST;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.addr))
        CFG_GATE_ENABLE:    cfg_q.gate_enable          <= cfg_i.data[0];
        CFG_GATE_THRESHOLD: cfg_q.gate_threshold_level <= cfg_i.data;
        CFG_RELEASE_COEFF:  cfg_q.release_coeff        <= cfg_i.data;
        CFG_TARGET_GAIN:    cfg_q.target_gain          <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/ng_serial_mult.sv @@
// Digit-serial unsigned multiplier: AW x 24 bits, one 4-bit digit of b per cycle.
`default_nettype none
module ng_serial_mult #(
  parameter int unsigned AW = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [AW-1:0]                   a_i,
  input  logic [ng_pkg::GAIN_W-1:0]       b_i,
  output logic                            done_o,
  output logic [AW+ng_pkg::GAIN_W-1:0]    prod_o
);
  import ng_pkg::*;

  localparam int unsigned PW = AW + GAIN_W;

  logic [AW-1:0]         a_q;
  logic [GAIN_W-1:0]     b_q;
  logic [PW-1:0]         acc_q;
  logic [DCNT_W-1:0]     cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic [AW+DIGIT_W-1:0] pp;
  logic [PW-1:0]         acc_d;

  // low digit first: accumulator shifts right one digit as each new
  // partial product enters at the top
  assign pp    = a_q * b_q[DIGIT_W-1:0];
  assign acc_d = (acc_q >> DIGIT_W) + {pp, {(GAIN_W - DIGIT_W){1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        a_q    <= a_i;
        b_q    <= b_i;
        acc_q  <= '0;
        cnt_q  <= DCNT_W'(NUM_DIGITS);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        acc_q <= acc_d;
        b_q   <= b_q >> DIGIT_W;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

@@ rtl/noise_gate_with_input_trim.sv @@
// Noise gate with peak detector, gate gain release and smoothed input trim.
// A new sample is accepted only in idle, once the last result has gone into the output
// register. Five products per item run on one shared 4-bit digit-serial multiplier.
// A result waiting at the output holds the sequencer until it is taken.
// Reset (async, active low): registers to defaults, peak 0, gate gain and trim gain 1.
`default_nettype none
module noise_gate_with_input_trim #(
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ng_in_if.sink     in_i,
  ng_out_if.source  out_o,
  ng_cfg_if.sink    cfg_i
);
  import ng_pkg::*;

  localparam int unsigned MW        = (SAMPLE_WIDTH > GAIN_W) ? SAMPLE_WIDTH : GAIN_W;
  localparam int unsigned PW        = MW + GAIN_W;
  localparam int unsigned RW        = PW - 19;
  localparam int unsigned ALIGN_SHR = (SAMPLE_WIDTH >= GAIN_W) ? SAMPLE_WIDTH - GAIN_W : 0;
  localparam int unsigned ALIGN_SHL = (SAMPLE_WIDTH < GAIN_W) ? GAIN_W - SAMPLE_WIDTH : 0;

  localparam logic [PW:0]   RND_23   = (PW+1)'(1) << 23;
  localparam logic [PW:0]   RND_23M1 = RND_23 - 1'b1;
  localparam logic [PW:0]   RND_22   = (PW+1)'(1) << 22;
  localparam logic [PW:0]   RND_19   = (PW+1)'(1) << 19;
  localparam logic [RW-1:0] POS_LIM  = (RW'(1) << (SAMPLE_WIDTH - 1)) - 1'b1;
  localparam logic [RW-1:0] NEG_LIM  = RW'(1) << (SAMPLE_WIDTH - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PEAK,
    S_PEAK_W,
    S_GATE,
    S_GATE_W,
    S_GATED,
    S_GATED_W,
    S_TRIM,
    S_TRIM_W,
    S_RES,
    S_RES_W,
    S_OUT
  } state_e;

  cfg_t cfg;

  ng_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  logic              mul_start;
  logic [MW-1:0]     mul_a;
  logic [GAIN_W-1:0] mul_b;
  logic              mul_done;
  logic [PW-1:0]     prod;

  ng_serial_mult #(.AW(MW)) u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  state_e                  state_q;
  logic [MW-1:0]           mag_q;
  logic                    neg_q;
  logic [GAIN_W-1:0]       level_q;
  logic [GAIN_W-1:0]       peak_q;
  logic [GAIN_W-1:0]       gate_q;
  logic [GAIN_W-1:0]       trim_q;
  logic [MW-1:0]           gated_q;
  logic [SAMPLE_WIDTH-1:0] res_q;
  logic                    out_valid_q;
  logic [SAMPLE_WIDTH-1:0] out_data_q;

  // input magnitude and detector level
  logic [SAMPLE_WIDTH-1:0] raw;
  logic                    in_neg;
  logic [SAMPLE_WIDTH-1:0] in_mag;
  logic [GAIN_W-1:0]       in_level;

  assign raw      = in_i.sample_in;
  assign in_neg   = raw[SAMPLE_WIDTH-1];
  assign in_mag   = in_neg ? (~raw + 1'b1) : raw;
  assign in_level = GAIN_W'((MW'(in_mag) >> ALIGN_SHR) << ALIGN_SHL);

  // operands derived from registers that stay put while a product runs
  logic              peak_rise;
  logic [GAIN_W-1:0] peak_diff;
  logic [GAIN_W-1:0] gate_target;
  logic              gate_rise;
  logic [GAIN_W-1:0] gate_diff;
  logic              trim_up;
  logic [GAIN_W-1:0] trim_diff;

  assign peak_rise   = level_q > peak_q;
  assign peak_diff   = peak_rise ? '0 : peak_q - level_q;
  assign gate_target = (peak_q > cfg.gate_threshold_level) ? ONE_Q23 : '0;
  assign gate_rise   = gate_target > gate_q;
  assign gate_diff   = gate_rise ? '0 : gate_q - gate_target;
  assign trim_up     = cfg.target_gain > trim_q;
  assign trim_diff   = trim_up ? cfg.target_gain - trim_q : trim_q - cfg.target_gain;

  // rounding of the finished product
  logic [PW:0]             sum_dec;
  logic [PW:0]             sum_trim;
  logic [PW:0]             sum_gated;
  logic [PW:0]             sum_res;
  logic [GAIN_W-1:0]       dec_step;
  logic [GAIN_W-1:0]       trim_step;
  logic [RW-1:0]           res_wide;
  logic [RW-1:0]           res_sat;
  logic [SAMPLE_WIDTH-1:0] res_mag;
  logic [SAMPLE_WIDTH-1:0] res_val;

  assign sum_dec   = {1'b0, prod} + RND_23;
  // toward a lower target the step rounds half down, so the blend rounds half up
  assign sum_trim  = {1'b0, prod} + (trim_up ? RND_23 : RND_23M1);
  assign sum_gated = {1'b0, prod} + RND_22;
  assign sum_res   = {1'b0, prod} + RND_19;
  assign dec_step  = sum_dec[2*GAIN_W-1:GAIN_W];
  assign trim_step = sum_trim[2*GAIN_W-1:GAIN_W];
  assign res_wide  = sum_res[PW:20];

  always_comb begin
    if (neg_q) begin
      res_sat = (res_wide > NEG_LIM) ? NEG_LIM : res_wide;
    end else begin
      res_sat = (res_wide > POS_LIM) ? POS_LIM : res_wide;
    end
    res_mag = res_sat[SAMPLE_WIDTH-1:0];
    res_val = neg_q ? (~res_mag + 1'b1) : res_mag;
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      S_PEAK: begin
        mul_start = 1'b1;
        mul_a     = MW'(peak_diff);
        mul_b     = cfg.release_coeff;
      end
      S_GATE: begin
        mul_start = 1'b1;
        mul_a     = MW'(gate_diff);
        mul_b     = cfg.release_coeff;
      end
      S_GATED: begin
        mul_start = 1'b1;
        mul_a     = mag_q;
        mul_b     = gate_q;
      end
      S_TRIM: begin
        mul_start = 1'b1;
        mul_a     = MW'(trim_diff);
        mul_b     = MOVE_W;
      end
      S_RES: begin
        mul_start = 1'b1;
        mul_a     = gated_q;
        mul_b     = trim_q;
      end
      default: ;
    endcase
  end

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      level_q     <= '0;
      peak_q      <= '0;
      gate_q      <= ONE_Q23;
      trim_q      <= ONE_Q20;
      gated_q     <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // in S_OUT the output register is reloaded below
      if (out_valid_q && out_o.ready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            mag_q   <= MW'(in_mag);
            neg_q   <= in_neg;
            level_q <= in_level;
            state_q <= S_PEAK;
          end
        end
        S_PEAK:  state_q <= S_PEAK_W;
        S_PEAK_W: begin
          if (mul_done) begin
            if (!cfg.gate_enable) begin
              peak_q <= '0;
            end else if (peak_rise) begin
              peak_q <= level_q;
            end else begin
              peak_q <= peak_q - dec_step;
            end
            state_q <= S_GATE;
          end
        end
        S_GATE:  state_q <= S_GATE_W;
        S_GATE_W: begin
          if (mul_done) begin
            if (!cfg.gate_enable) begin
              gate_q <= ONE_Q23;
            end else if (gate_rise) begin
              gate_q <= gate_target;
            end else begin
              gate_q <= gate_q - dec_step;
            end
            state_q <= S_GATED;
          end
        end
        S_GATED: state_q <= S_GATED_W;
        S_GATED_W: begin
          if (mul_done) begin
            gated_q <= cfg.gate_enable ? sum_gated[23 +: MW] : mag_q;
            state_q <= S_TRIM;
          end
        end
        S_TRIM:  state_q <= S_TRIM_W;
        S_TRIM_W: begin
          if (mul_done) begin
            if (trim_diff <= EPS_Q20) begin
              trim_q <= cfg.target_gain;
            end else if (trim_up) begin
              trim_q <= trim_q + trim_step;
            end else begin
              trim_q <= trim_q - trim_step;
            end
            state_q <= S_RES;
          end
        end
        S_RES:   state_q <= S_RES_W;
        S_RES_W: begin
          if (mul_done) begin
            res_q   <= res_val;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_data_q  <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the noise gate with smoothed input trim.
`timescale 1ns / 100ps
module tb_top;
  import ng_pkg::*;

  localparam int SW            = 24;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 50;
  localparam logic [63:0]       KEEP_WEIGHT = (64'd1 << 24) - 64'(MOVE_W);
  localparam logic [SW-1:0]     MAX_POS     = 24'h7FFFFF;
  localparam logic [SW-1:0]     MIN_NEG     = 24'h800000;
  localparam logic [SW-1:0]     MINUS_ONE   = 24'hFFFFFF;
  localparam logic [GAIN_W-1:0] GAIN_MAX    = 24'hFFFFFF;

  logic clk;
  logic rst_n;
  int   idle_pct = 38;
  int   mismatches = 0;
  int   stall_cycles = 0;

  // shadow of the block's registers and state
  cfg_t              cfg_sh;
  logic [GAIN_W-1:0] peak_lvl;
  logic [GAIN_W-1:0] gate_g;
  logic [GAIN_W-1:0] trim_g;
  logic [SW-1:0]     out_samples_q[$];

  ng_in_if  #(.SAMPLE_WIDTH(SW)) in_if ();
  ng_out_if #(.SAMPLE_WIDTH(SW)) out_if ();
  ng_cfg_if                      cfg_if ();

  noise_gate_with_input_trim #(.SAMPLE_WIDTH(SW)) uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // value falls toward goal (goal <= value) by diff * release / 2^24, rounded
  function automatic logic [GAIN_W-1:0] decay_step(input logic [GAIN_W-1:0] value,
                                                   input logic [GAIN_W-1:0] goal);
    logic [63:0] diff;
    logic [63:0] stp;
    diff = 64'(value) - 64'(goal);
    stp  = (diff * 64'(cfg_sh.release_coeff) + (64'd1 << 23)) >> 24;
    return value - stp[GAIN_W-1:0];
  endfunction

  function automatic logic [63:0] round_mul(input logic [63:0] a, input logic [63:0] g,
                                            input int frac);
    return (a * g + (64'd1 << (frac - 1))) >> frac;
  endfunction

  // expected output for one item; advances the shadow state
  function automatic logic [SW-1:0] gate_and_trim(input logic [SW-1:0] raw);
    logic              neg;
    logic [63:0]       mag;
    logic [63:0]       gated;
    logic [63:0]       res;
    logic [63:0]       acc;
    logic [GAIN_W-1:0] level;
    logic [GAIN_W-1:0] target;
    logic [GAIN_W-1:0] gap;
    neg = raw[SW-1];
    mag = neg ? ((64'd1 << SW) - 64'(raw)) : 64'(raw);
    if (cfg_sh.gate_enable) begin
      level = mag[GAIN_W-1:0];
      if (level > peak_lvl) peak_lvl = level;
      else peak_lvl = decay_step(peak_lvl, level);
      target = (peak_lvl > cfg_sh.gate_threshold_level) ? ONE_Q23 : '0;
      if (target > gate_g) gate_g = target;
      else gate_g = decay_step(gate_g, target);
      gated = round_mul(mag, 64'(gate_g), 23);
    end else begin
      peak_lvl = '0;
      gate_g   = ONE_Q23;
      gated    = mag;
    end
    gap = (cfg_sh.target_gain > trim_g) ? cfg_sh.target_gain - trim_g
                                        : trim_g - cfg_sh.target_gain;
    if (gap > EPS_Q20) begin
      acc = 64'(trim_g) * KEEP_WEIGHT + 64'(cfg_sh.target_gain) * 64'(MOVE_W) + (64'd1 << 23);
      trim_g = acc[GAIN_W+23:24];
    end else begin
      trim_g = cfg_sh.target_gain;
    end
    res = round_mul(gated, 64'(trim_g), 20);
    if (neg) begin
      if (res > (64'd1 << (SW - 1))) res = 64'd1 << (SW - 1);
      return SW'((64'd1 << SW) - res);
    end
    if (res > (64'd1 << (SW - 1)) - 1) res = (64'd1 << (SW - 1)) - 1;
    return SW'(res);
  endfunction

  // trim target within epsilon of the current trim gain, either side
  function automatic logic [GAIN_W-1:0] near_trim();
    int t;
    t = int'(trim_g) + int'($urandom_range(210)) - 105;
    if (t < 0) t = 0;
    if (t > int'(GAIN_MAX)) t = int'(GAIN_MAX);
    return GAIN_W'(t);
  endfunction

  task automatic send_sample(input logic [SW-1:0] s);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.sample_in <= s;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    out_samples_q.push_back(gate_and_trim(s));
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (out_samples_q.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [GAIN_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_GATE_ENABLE:    cfg_sh.gate_enable          = val[0];
      CFG_GATE_THRESHOLD: cfg_sh.gate_threshold_level = val;
      CFG_RELEASE_COEFF:  cfg_sh.release_coeff        = val;
      default:            cfg_sh.target_gain          = val;
    endcase
    @(posedge clk);
  endtask

  // reset settings: gate bypassed, unity trim
  task automatic test_bypass_trim();
    send_sample('0);
    send_sample(SW'(1));
    send_sample(MINUS_ONE);
    send_sample(MAX_POS);
    send_sample(MIN_NEG);
    send_sample(SW'(12345));
  endtask

  // loud items open the gate, silence lets the peak level release while the gate stays open
  task automatic test_gate_release();
    drain_results();
    write_reg(CFG_GATE_ENABLE, GAIN_W'(1));
    write_reg(CFG_GATE_THRESHOLD, THRESHOLD_RST);
    write_reg(CFG_RELEASE_COEFF, 24'h400000);
    send_sample(MAX_POS);
    send_sample(MIN_NEG);
    repeat (6) send_sample('0);
    send_sample(SW'(839));
    send_sample(SW'(-839));
  endtask

  // trim ramps toward max gain so full-scale items clip, then snaps within epsilon
  task automatic test_trim_saturation();
    drain_results();
    write_reg(CFG_GATE_ENABLE, '0);
    write_reg(CFG_TARGET_GAIN, GAIN_MAX);
    send_sample(MAX_POS);
    send_sample(MIN_NEG);
    send_sample(MAX_POS);
    send_sample(MIN_NEG);
    send_sample(SW'(4000000));
    send_sample(SW'(-4000000));
    drain_results();
    write_reg(CFG_TARGET_GAIN, near_trim());
    send_sample(SW'(3000000));
    send_sample(SW'(-3000000));
  endtask

  task automatic test_random_phases(input int phases, input int per_phase);
    logic              en;
    logic [GAIN_W-1:0] thr;
    logic [GAIN_W-1:0] rel;
    logic [GAIN_W-1:0] tgt;
    logic [SW-1:0]     v;
    int                sent;
    int                loud;
    int                quiet;
    int                lim;
    bit                paused;
    for (int p = 0; p < phases; p++) begin
      drain_results();
      case (p)
        0: begin en = 1'b1; thr = '0; rel = GAIN_MAX; tgt = ONE_Q20; end
        1: begin en = 1'b1; thr = ONE_Q23; rel = '0; tgt = '0; end
        2: begin
          en = 1'b0; thr = GAIN_W'($urandom_range(ONE_Q23)); rel = GAIN_W'($urandom);
          tgt = GAIN_MAX;
        end
        3: begin
          en = 1'b1; thr = GAIN_W'($urandom_range(2000));
          rel = GAIN_W'($urandom_range(400000)); tgt = near_trim();
        end
        default: begin
          en = ($urandom_range(3) != 0);
          case ($urandom_range(3))
            0:       thr = '0;
            1:       thr = ONE_Q23;
            2:       thr = GAIN_W'($urandom_range(ONE_Q23));
            default: thr = GAIN_W'($urandom_range(20000));
          endcase
          case ($urandom_range(3))
            0:       rel = '0;
            1:       rel = GAIN_MAX;
            2:       rel = GAIN_W'($urandom);
            default: rel = GAIN_W'($urandom_range(300000));
          endcase
          case ($urandom_range(4))
            0:       tgt = '0;
            1:       tgt = GAIN_MAX;
            2:       tgt = ONE_Q20;
            3:       tgt = near_trim();
            default: tgt = GAIN_W'($urandom);
          endcase
        end
      endcase
      // one phase runs with no idling on either side
      idle_pct = (p == 5) ? 0 : 38;
      write_reg(CFG_GATE_ENABLE, GAIN_W'(en));
      write_reg(CFG_GATE_THRESHOLD, thr);
      write_reg(CFG_RELEASE_COEFF, rel);
      write_reg(CFG_TARGET_GAIN, tgt);
      sent   = 0;
      paused = 1'b0;
      while (sent < per_phase) begin
        if (p == 7 && !paused && sent >= per_phase / 2) begin
          drain_results();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 70) begin
          // burst of loud items, then quiet ones around the threshold
          loud  = $urandom_range(6, 1);
          quiet = $urandom_range(16, 1);
          repeat (loud) begin
            send_sample(SW'($urandom));
            sent++;
          end
          lim = 2 * int'(cfg_sh.gate_threshold_level) + 16;
          if (lim > int'(MAX_POS)) lim = int'(MAX_POS);
          repeat (quiet) begin
            v = SW'($urandom_range(lim));
            if ($urandom_range(1)) v = -v;
            send_sample(v);
            sent++;
          end
        end else begin
          case ($urandom_range(4))
            0:       v = MAX_POS;
            1:       v = MIN_NEG;
            2:       v = '0;
            3:       v = $urandom_range(1) ? SW'(1) : MINUS_ONE;
            default: v = SW'($urandom);
          endcase
          send_sample(v);
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    logic [SW-1:0] want;
    out_if.ready <= ($urandom_range(99) >= idle_pct);
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (out_samples_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected sample_out item, expected none, got %0d", $time,
                 $signed(out_if.sample_out));
      end else begin
        want = out_samples_q.pop_front();
        if (out_if.sample_out !== want) begin
          mismatches++;
          $display("%0t: sample_out expected %0d, got %0d", $time, $signed(want),
                   $signed(out_if.sample_out));
        end
      end
    end
  end

  // counts cycles with no item moving on any channel
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("noise_gate_with_input_trim test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.sample_in  = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.addr      = CFG_GATE_ENABLE;
    cfg_if.data      = '0;
    cfg_sh           = {1'b0, THRESHOLD_RST, RELEASE_RST, TARGET_RST};
    peak_lvl         = '0;
    gate_g           = ONE_Q23;
    trim_g           = ONE_Q20;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_bypass_trim();
    test_gate_release();
    test_trim_saturation();
    test_random_phases(11, 50);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("noise_gate_with_input_trim test passed");
    end else begin
      $display("noise_gate_with_input_trim test failed");
    end
    $finish;
  end

endmodule
